[rtl/utrb_pkg.sv]
// utrb_pkg: shared types, constants and small helper functions for the
// seconds-to-RTC-register converter. No dependencies.
`default_nettype none

package utrb_pkg;

   // Input and split widths
   localparam int UTC_W       = 40;
   localparam int DAYS_W      = 24;            // biased day number, always >= 0
   localparam int REM_W       = 17;            // second of day, 0..86399
   localparam int SEC_DIV_LOW = 7;             // 86400 = 2^7 * 675
   localparam int SEC_DIV_ODD = 675;
   localparam int DIVR_W      = 10;            // remainder of the divide by 675
   localparam int Q1_W        = DAYS_W + DIVR_W;
   localparam int DIV_STEPS   = 8;             // quotient bits per division stage
   localparam int DIV_STAGES  = DAYS_W / DIV_STEPS;

   // Day bias: biased day = floor(t / 86400) + DAY_BIAS, never negative
   localparam longint DAY_BIAS = 6362915;
   localparam logic [Q1_W-1:0] Q1_BIAS = Q1_W'(DAY_BIAS * SEC_DIV_ODD);

   // Time of day
   localparam int     HOUR_W        = 5;
   localparam int     SOH_W         = 12;      // second of hour
   localparam int     MIN_W         = 6;
   localparam longint SECS_PER_HOUR = 3600;
   localparam longint SECS_PER_MIN  = 60;
   localparam int     HOUR_SH       = 29;
   localparam int     HOUR_MUL_W    = 18;
   localparam logic [HOUR_MUL_W-1:0] HOUR_MUL = HOUR_MUL_W'(
      ((longint'(1) << HOUR_SH) + SECS_PER_HOUR - 1) / SECS_PER_HOUR);
   localparam int     MIN_SH        = 18;
   localparam int     MIN_MUL_W     = 13;
   localparam logic [MIN_MUL_W-1:0] MIN_MUL = MIN_MUL_W'(
      ((longint'(1) << MIN_SH) + SECS_PER_MIN - 1) / SECS_PER_MIN);

   // Civil date
   localparam longint EPOCH_SHIFT   = 719468;
   localparam longint DAYS_PER_ERA  = 146097;
   localparam longint ERA_BIAS      = 44;      // keeps the era number positive
   localparam longint YEARS_PER_ERA = 400;
   localparam longint EPOCH_WEEKDAY = 4;       // 1970-01-01 was a Thursday
   localparam logic [DAYS_W-1:0] Z_BIAS = DAYS_W'(
      EPOCH_SHIFT + ERA_BIAS * DAYS_PER_ERA - DAY_BIAS);
   localparam logic [5:0] WD_BIAS = 6'(((EPOCH_WEEKDAY - (DAY_BIAS % 7)) + 7) % 7);

   localparam int ERA_W     = 7;
   localparam int ERA_SH    = 42;
   localparam int ERA_MUL_W = 25;
   localparam logic [ERA_MUL_W-1:0] ERA_MUL = ERA_MUL_W'(
      ((longint'(1) << ERA_SH) + DAYS_PER_ERA - 1) / DAYS_PER_ERA);

   localparam int DOE_W     = 18;
   localparam int DOE_MUL_W = 19;
   localparam int Q4Y_SH    = 29;              // divide by 1460
   localparam logic [DOE_MUL_W-1:0] Q4Y_MUL = DOE_MUL_W'(
      ((longint'(1) << Q4Y_SH) + 1460 - 1) / 1460);
   localparam int Q100Y_SH  = 34;              // divide by 36524
   localparam logic [DOE_MUL_W-1:0] Q100Y_MUL = DOE_MUL_W'(
      ((longint'(1) << Q100Y_SH) + 36524 - 1) / 36524);
   localparam int YEAR_SH   = 27;              // divide by 365
   localparam logic [DOE_MUL_W-1:0] YEAR_MUL = DOE_MUL_W'(
      ((longint'(1) << YEAR_SH) + 365 - 1) / 365);
   localparam logic [DOE_W-1:0] LAST_DOE = DOE_W'(DAYS_PER_ERA - 1);

   localparam int YOE_W     = 9;
   localparam int CENT_SH   = 16;              // divide by 100
   localparam int CENT_MUL_W = 10;
   localparam logic [CENT_MUL_W-1:0] CENT_MUL = CENT_MUL_W'(
      ((longint'(1) << CENT_SH) + 100 - 1) / 100);

   localparam int DOY_W     = 9;
   localparam int MP_W      = 4;
   localparam int MP_SH     = 19;              // divide by 153
   localparam int MP_MUL_W  = 15;
   localparam longint MP_BASE = ((longint'(1) << MP_SH) + 153 - 1) / 153;
   localparam logic [MP_MUL_W-1:0] MP_MUL5 = MP_MUL_W'(5 * MP_BASE);
   localparam logic [MP_MUL_W-1:0] MP_ADD  = MP_MUL_W'(2 * MP_BASE);
   localparam logic [MP_W-1:0]     MP_JAN  = MP_W'(10);
   localparam logic [MP_W-1:0]     MARCH_OFS = MP_W'(3);
   localparam logic [MP_W-1:0]     JAN_OFS   = MP_W'(9);

   localparam int YFULL_W = 16;
   localparam logic [YFULL_W-1:0] Y_LO = YFULL_W'(2000 + ERA_BIAS * YEARS_PER_ERA);
   localparam logic [YFULL_W-1:0] Y_HI = YFULL_W'(2099 + ERA_BIAS * YEARS_PER_ERA);
   localparam logic [YFULL_W-1:0] YEARS_ERA = YFULL_W'(YEARS_PER_ERA);

   localparam int DAYM_W  = 5;
   localparam int WDAY_W  = 3;

   // Two-digit BCD of a value below 100: tens by reciprocal multiply
   localparam int BCD_SH  = 11;
   localparam logic [7:0] BCD_MUL = 8'(((longint'(1) << BCD_SH) + 10 - 1) / 10);

   // Output field widths
   localparam int SEC_BCD_W  = 7;
   localparam int MIN_BCD_W  = 7;
   localparam int HOUR_BCD_W = 6;
   localparam int DAY_BCD_W  = 6;
   localparam int MON_BCD_W  = 5;
   localparam int YEAR_BCD_W = 8;

   // Pipeline depth
   localparam int DAY_LAT     = 1 + DIV_STAGES;
   localparam int CIV_LAT     = 11;
   localparam int TOD_LAT     = 5;
   localparam int TOD_DELAY   = CIV_LAT - TOD_LAT;
   localparam int RSP_LATENCY = DAY_LAT + CIV_LAT;

   // Long division state by 675: remainder, dividend bits shifting out and
   // quotient bits shifting in, low bits of the count riding along
   typedef struct packed {
      logic                   valid;
      logic [DIVR_W-1:0]      rmd;
      logic [DAYS_W-1:0]      num;
      logic [SEC_DIV_LOW-1:0] low;
   } div_state_type;

   typedef struct packed {
      logic [SEC_BCD_W-1:0]  seconds_bcd;
      logic [MIN_BCD_W-1:0]  minutes_bcd;
      logic [HOUR_BCD_W-1:0] hours_bcd;
   } tod_bcd_type;

   typedef struct packed {
      logic                  valid;
      logic [DAY_BCD_W-1:0]  day_bcd;
      logic [WDAY_W-1:0]     weekday;
      logic [MON_BCD_W-1:0]  month_bcd;
      logic [YEAR_BCD_W-1:0] year_bcd;
   } date_bcd_type;

   function automatic logic [7:0] bcd2(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(v) * 15'(BCD_MUL);
      tens = prod[14:BCD_SH];
      ones = v - 7'(tens) * 7'd10;
      return {tens, ones[3:0]};
   endfunction

   // Octal digits of a number sum to the same residue mod 7
   function automatic logic [WDAY_W-1:0] mod7(input logic [5:0] x);
      logic [3:0] f1;
      logic [3:0] f2;
      f1 = 4'(x[5:3]) + 4'(x[2:0]);
      f2 = 4'(f1[3]) + 4'(f1[2:0]);
      return (f2 == 4'd7) ? 3'd0 : f2[2:0];
   endfunction

   // First day of each March-based month within its year
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] start;
      case (mp)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

`default_nettype wire

[rtl/utrb_div_stage.sv]
// utrb_div_stage: one register stage of the restoring divide by 675,
// DIV_STEPS quotient bits per stage. Depends on utrb_pkg.
`default_nettype none

module utrb_div_stage import utrb_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire div_state_type prev_state,
   output div_state_type      next_state
);

   div_state_type    state_in;
   div_state_type    state_ff;
   logic [DIVR_W:0]  trial;
   logic             fits;

   always_comb begin
      state_in = prev_state;
      trial    = '0;
      fits     = 1'b0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {state_in.rmd, state_in.num[DAYS_W-1]};
         fits  = (trial >= (DIVR_W+1)'(SEC_DIV_ODD));
         state_in.rmd = fits ? DIVR_W'(trial - (DIVR_W+1)'(SEC_DIV_ODD))
                             : DIVR_W'(trial);
         state_in.num = {state_in.num[DAYS_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign next_state = state_ff;

endmodule

`default_nettype wire

[rtl/utrb_day_split.sv]
// utrb_day_split: floor split of the signed second count into a biased day
// number and second of day. Depends on utrb_pkg and utrb_div_stage.
`default_nettype none

module utrb_day_split import utrb_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic signed [UTC_W-1:0]  utc_seconds,
   output div_state_type                 split
);

   logic signed [UTC_W-1:0] shifted;
   logic [Q1_W-1:0]         q1;
   div_state_type           entry_in;
   div_state_type           entry_ff;
   div_state_type           chain [DIV_STAGES+1];

   // floor(t / 128) biased to a positive value; the sum fits in Q1_W bits
   assign shifted = utc_seconds >>> SEC_DIV_LOW;
   assign q1      = shifted[Q1_W-1:0] + Q1_BIAS;

   always_comb begin
      entry_in.valid = accept;
      entry_in.rmd   = q1[Q1_W-1:DAYS_W];
      entry_in.num   = q1[DAYS_W-1:0];
      entry_in.low   = utc_seconds[SEC_DIV_LOW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign chain[0] = entry_ff;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      utrb_div_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .prev_state (chain[g]),
         .next_state (chain[g+1])
      );
   end

   assign split = chain[DIV_STAGES];

endmodule

`default_nettype wire

[rtl/utrb_clock_fields.sv]
// utrb_clock_fields: second of day to BCD hour, minute and second, delayed
// to line up with the date path. Depends on utrb_pkg.
`default_nettype none

module utrb_clock_fields import utrb_pkg::*; (
   input  wire logic             clock,
   input  wire logic [REM_W-1:0] sod,
   output tod_bcd_type           fields
);

   typedef struct packed {
      logic [REM_W-1:0]  sod;
      logic [HOUR_W-1:0] hour;
   } tod1_type;

   typedef struct packed {
      logic [SOH_W-1:0]  soh;
      logic [HOUR_W-1:0] hour;
   } tod2_type;

   typedef struct packed {
      logic [SOH_W-1:0]  soh;
      logic [MIN_W-1:0]  minute;
      logic [HOUR_W-1:0] hour;
   } tod3_type;

   typedef struct packed {
      logic [MIN_W-1:0]  second;
      logic [MIN_W-1:0]  minute;
      logic [HOUR_W-1:0] hour;
   } tod4_type;

   localparam int HP_W = REM_W + HOUR_MUL_W;
   localparam int MP_PW = SOH_W + MIN_MUL_W;

   logic [HP_W-1:0]  hour_prod;
   logic [MP_PW-1:0] min_prod;
   tod1_type    t1_in, t1_ff;
   tod2_type    t2_in, t2_ff;
   tod3_type    t3_in, t3_ff;
   tod4_type    t4_in, t4_ff;
   tod_bcd_type t5_in, t5_ff;
   tod_bcd_type delay_ff [TOD_DELAY];

   assign hour_prod = HP_W'(sod) * HP_W'(HOUR_MUL);
   assign t1_in.sod  = sod;
   assign t1_in.hour = hour_prod[HOUR_SH +: HOUR_W];

   assign t2_in.soh  = SOH_W'(t1_ff.sod - REM_W'(t1_ff.hour) * REM_W'(SECS_PER_HOUR));
   assign t2_in.hour = t1_ff.hour;

   assign min_prod     = MP_PW'(t2_ff.soh) * MP_PW'(MIN_MUL);
   assign t3_in.soh    = t2_ff.soh;
   assign t3_in.minute = min_prod[MIN_SH +: MIN_W];
   assign t3_in.hour   = t2_ff.hour;

   assign t4_in.second = MIN_W'(t3_ff.soh - SOH_W'(t3_ff.minute) * SOH_W'(SECS_PER_MIN));
   assign t4_in.minute = t3_ff.minute;
   assign t4_in.hour   = t3_ff.hour;

   always_comb begin
      t5_in.seconds_bcd = SEC_BCD_W'(bcd2(7'(t4_ff.second)));
      t5_in.minutes_bcd = MIN_BCD_W'(bcd2(7'(t4_ff.minute)));
      t5_in.hours_bcd   = HOUR_BCD_W'(bcd2(7'(t4_ff.hour)));
   end

   always_ff @(posedge clock) begin
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      t3_ff       <= t3_in;
      t4_ff       <= t4_in;
      t5_ff       <= t5_in;
      delay_ff[0] <= t5_ff;
      for (int i = 1; i < TOD_DELAY; i++) begin
         delay_ff[i] <= delay_ff[i-1];
      end
   end

   assign fields = delay_ff[TOD_DELAY-1];

endmodule

`default_nettype wire

[rtl/utrb_civil_date.sv]
// utrb_civil_date: biased day number to weekday and BCD day, month and year
// through 400-year eras. Depends on utrb_pkg.
`default_nettype none

module utrb_civil_date import utrb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [DAYS_W-1:0] days,
   output date_bcd_type           date
);

   typedef struct packed {
      logic              valid;
      logic [DAYS_W-1:0] zp;
      logic [WDAY_W-1:0] wd;
   } c1_type;

   typedef struct packed {
      logic              valid;
      logic [DAYS_W-1:0] zp;
      logic [ERA_W-1:0]  era;
      logic [WDAY_W-1:0] wd;
   } c2_type;

   typedef struct packed {
      logic              valid;
      logic [DOE_W-1:0]  doe;
      logic [ERA_W-1:0]  era;
      logic [WDAY_W-1:0] wd;
   } c3_type;

   typedef struct packed {
      logic              valid;
      logic [DOE_W-1:0]  doe;
      logic [6:0]        q4y;
      logic [2:0]        q100y;
      logic              last;
      logic [ERA_W-1:0]  era;
      logic [WDAY_W-1:0] wd;
   } c4_type;

   typedef struct packed {
      logic              valid;
      logic [DOE_W-1:0]  doe;
      logic [DOE_W-1:0]  tv;
      logic [ERA_W-1:0]  era;
      logic [WDAY_W-1:0] wd;
   } c5_type;

   typedef struct packed {
      logic              valid;
      logic [DOE_W-1:0]  doe;
      logic [YOE_W-1:0]  yoe;
      logic [ERA_W-1:0]  era;
      logic [WDAY_W-1:0] wd;
   } c6_type;

   typedef struct packed {
      logic              valid;
      logic [DOE_W-1:0]  doe;
      logic [YOE_W-1:0]  yoe;
      logic [2:0]        cent;
      logic [ERA_W-1:0]  era;
      logic [WDAY_W-1:0] wd;
   } c7_type;

   typedef struct packed {
      logic               valid;
      logic [DOY_W-1:0]   doy;
      logic [YFULL_W-1:0] ybase;
      logic [WDAY_W-1:0]  wd;
   } c8_type;

   typedef struct packed {
      logic               valid;
      logic [DOY_W-1:0]   doy;
      logic [MP_W-1:0]    mp;
      logic [YFULL_W-1:0] ybase;
      logic [WDAY_W-1:0]  wd;
   } c9_type;

   typedef struct packed {
      logic               valid;
      logic [DAYM_W-1:0]  day;
      logic [MP_W-1:0]    month;
      logic [YFULL_W-1:0] yfull;
      logic [WDAY_W-1:0]  wd;
   } c10_type;

   localparam int EP_W = DAYS_W + ERA_MUL_W;
   localparam int DP_W = DOE_W + DOE_MUL_W;
   localparam int CP_W = YOE_W + CENT_MUL_W;
   localparam int MPP_W = DOY_W + MP_MUL_W;

   c1_type       c1_in, c1_ff;
   c2_type       c2_in, c2_ff;
   c3_type       c3_in, c3_ff;
   c4_type       c4_in, c4_ff;
   c5_type       c5_in, c5_ff;
   c6_type       c6_in, c6_ff;
   c7_type       c7_in, c7_ff;
   c8_type       c8_in, c8_ff;
   c9_type       c9_in, c9_ff;
   c10_type      c10_in, c10_ff;
   date_bcd_type c11_in, c11_ff;

   logic [5:0]       wsum;
   logic [EP_W-1:0]  era_prod;
   logic [DP_W-1:0]  q4y_prod;
   logic [DP_W-1:0]  q100y_prod;
   logic [DP_W-1:0]  year_prod;
   logic [CP_W-1:0]  cent_prod;
   logic [MPP_W-1:0] mp_prod;
   logic [6:0]       year_off;

   // Shift the day onto the era grid and take the weekday from octal digits
   always_comb begin
      wsum = WD_BIAS;
      for (int i = 0; i < DAYS_W / 3; i++) begin
         wsum = wsum + 6'(days[3*i +: 3]);
      end
      c1_in.valid = in_valid;
      c1_in.zp    = days + Z_BIAS;
      c1_in.wd    = mod7(wsum);
   end

   assign era_prod = EP_W'(c1_ff.zp) * EP_W'(ERA_MUL);
   always_comb begin
      c2_in.valid = c1_ff.valid;
      c2_in.zp    = c1_ff.zp;
      c2_in.era   = era_prod[ERA_SH +: ERA_W];
      c2_in.wd    = c1_ff.wd;
   end

   always_comb begin
      c3_in.valid = c2_ff.valid;
      c3_in.doe   = DOE_W'(c2_ff.zp - DAYS_W'(c2_ff.era) * DAYS_W'(DAYS_PER_ERA));
      c3_in.era   = c2_ff.era;
      c3_in.wd    = c2_ff.wd;
   end

   assign q4y_prod   = DP_W'(c3_ff.doe) * DP_W'(Q4Y_MUL);
   assign q100y_prod = DP_W'(c3_ff.doe) * DP_W'(Q100Y_MUL);
   always_comb begin
      c4_in.valid = c3_ff.valid;
      c4_in.doe   = c3_ff.doe;
      c4_in.q4y   = q4y_prod[Q4Y_SH +: 7];
      c4_in.q100y = q100y_prod[Q100Y_SH +: 3];
      c4_in.last  = (c3_ff.doe == LAST_DOE);
      c4_in.era   = c3_ff.era;
      c4_in.wd    = c3_ff.wd;
   end

   // Remove the leap days so one divide by 365 gives the year of era
   always_comb begin
      c5_in.valid = c4_ff.valid;
      c5_in.doe   = c4_ff.doe;
      c5_in.tv    = c4_ff.doe - DOE_W'(c4_ff.q4y) + DOE_W'(c4_ff.q100y)
                    - DOE_W'(c4_ff.last);
      c5_in.era   = c4_ff.era;
      c5_in.wd    = c4_ff.wd;
   end

   assign year_prod = DP_W'(c5_ff.tv) * DP_W'(YEAR_MUL);
   always_comb begin
      c6_in.valid = c5_ff.valid;
      c6_in.doe   = c5_ff.doe;
      c6_in.yoe   = year_prod[YEAR_SH +: YOE_W];
      c6_in.era   = c5_ff.era;
      c6_in.wd    = c5_ff.wd;
   end

   assign cent_prod = CP_W'(c6_ff.yoe) * CP_W'(CENT_MUL);
   always_comb begin
      c7_in.valid = c6_ff.valid;
      c7_in.doe   = c6_ff.doe;
      c7_in.yoe   = c6_ff.yoe;
      c7_in.cent  = cent_prod[CENT_SH +: 3];
      c7_in.era   = c6_ff.era;
      c7_in.wd    = c6_ff.wd;
   end

   always_comb begin
      c8_in.valid = c7_ff.valid;
      c8_in.doy   = DOY_W'(c7_ff.doe - (DOE_W'(c7_ff.yoe) * DOE_W'(365)
                    + DOE_W'(c7_ff.yoe[YOE_W-1:2]) - DOE_W'(c7_ff.cent)));
      c8_in.ybase = YFULL_W'(c7_ff.yoe) + YFULL_W'(c7_ff.era) * YEARS_ERA;
      c8_in.wd    = c7_ff.wd;
   end

   // (5*doy + 2) / 153 folded into one multiply and add
   assign mp_prod = MPP_W'(c8_ff.doy) * MPP_W'(MP_MUL5) + MPP_W'(MP_ADD);
   always_comb begin
      c9_in.valid = c8_ff.valid;
      c9_in.doy   = c8_ff.doy;
      c9_in.mp    = mp_prod[MP_SH +: MP_W];
      c9_in.ybase = c8_ff.ybase;
      c9_in.wd    = c8_ff.wd;
   end

   // January and February belong to the next calendar year
   always_comb begin
      c10_in.valid = c9_ff.valid;
      c10_in.day   = DAYM_W'(c9_ff.doy - month_start(c9_ff.mp) + DOY_W'(1));
      c10_in.month = (c9_ff.mp < MP_JAN) ? c9_ff.mp + MARCH_OFS : c9_ff.mp - JAN_OFS;
      c10_in.yfull = c9_ff.ybase + YFULL_W'(c9_ff.mp >= MP_JAN);
      c10_in.wd    = c9_ff.wd;
   end

   always_comb begin
      year_off         = ((c10_ff.yfull >= Y_LO) && (c10_ff.yfull <= Y_HI))
                         ? 7'(c10_ff.yfull - Y_LO) : 7'd0;
      c11_in.valid     = c10_ff.valid;
      c11_in.day_bcd   = DAY_BCD_W'(bcd2(7'(c10_ff.day)));
      c11_in.weekday   = c10_ff.wd;
      c11_in.month_bcd = MON_BCD_W'(bcd2(7'(c10_ff.month)));
      c11_in.year_bcd  = bcd2(year_off);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff  <= '0;
         c2_ff  <= '0;
         c3_ff  <= '0;
         c4_ff  <= '0;
         c5_ff  <= '0;
         c6_ff  <= '0;
         c7_ff  <= '0;
         c8_ff  <= '0;
         c9_ff  <= '0;
         c10_ff <= '0;
         c11_ff <= '0;
      end else begin
         c1_ff  <= c1_in;
         c2_ff  <= c2_in;
         c3_ff  <= c3_in;
         c4_ff  <= c4_in;
         c5_ff  <= c5_in;
         c6_ff  <= c6_in;
         c7_ff  <= c7_in;
         c8_ff  <= c8_in;
         c9_ff  <= c9_in;
         c10_ff <= c10_in;
         c11_ff <= c11_in;
      end
   end

   assign date = c11_ff;

endmodule

`default_nettype wire

[rtl/unix_time_to_rtc_bcd.sv]
// unix_time_to_rtc_bcd: top level of the seconds-to-RTC-register converter.
// Depends on utrb_pkg, utrb_day_split, utrb_clock_fields, utrb_civil_date.
//
// Converts a signed 40-bit count of seconds since 1970-01-01 00:00 UTC into
// the seven RTC register fields: BCD second, minute and hour, BCD day of
// month, binary weekday (0 = Sunday), BCD month and a BCD two-digit year
// that reads 00 outside 2000..2099. Negative counts round the day toward
// minus infinity. A transaction is taken on a clock edge with start high and
// busy low; busy is high only during reset and the cycle after it, so one
// transaction can be issued every clock. Each result appears on the rsp_
// ports with rsp_valid high for exactly one cycle, in issue order; the
// receiver cannot stall it. Between a transaction being taken and its
// result lie one input register, three stages of an eight-bit-per-stage
// restoring divide by 675 that finishes the split of the count into day and
// second of day, and eleven stages of the date path (era, year, month and
// day recovered through constant reciprocal multiplies). The time-of-day
// path is shorter and is delayed to line up with the date.
`default_nettype none

module unix_time_to_rtc_bcd import utrb_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic signed [UTC_W-1:0] req_utc_seconds,
   output logic                         rsp_valid,
   output logic [SEC_BCD_W-1:0]         rsp_seconds_bcd,
   output logic [MIN_BCD_W-1:0]         rsp_minutes_bcd,
   output logic [HOUR_BCD_W-1:0]        rsp_hours_bcd,
   output logic [DAY_BCD_W-1:0]         rsp_day_bcd,
   output logic [WDAY_W-1:0]            rsp_weekday,
   output logic [MON_BCD_W-1:0]         rsp_month_bcd,
   output logic [YEAR_BCD_W-1:0]        rsp_year_bcd
);

   logic          busy_ff;
   logic          accept;
   div_state_type split;
   tod_bcd_type   tod;
   date_bcd_type  date;

   // Hold off transactions while the pipeline valids are being cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // Day number and second of day
   utrb_day_split u_day_split (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .utc_seconds (req_utc_seconds),
      .split       (split)
   );

   // Second of day is the division remainder followed by the low seven bits
   utrb_clock_fields u_clock_fields (
      .clock  (clock),
      .sod    ({split.rmd, split.low}),
      .fields (tod)
   );

   // The date path carries the transaction valid
   utrb_civil_date u_civil_date (
      .clock    (clock),
      .reset    (reset),
      .in_valid (split.valid),
      .days     (split.num),
      .date     (date)
   );

   assign rsp_valid       = date.valid;
   assign rsp_seconds_bcd = tod.seconds_bcd;
   assign rsp_minutes_bcd = tod.minutes_bcd;
   assign rsp_hours_bcd   = tod.hours_bcd;
   assign rsp_day_bcd     = date.day_bcd;
   assign rsp_weekday     = date.weekday;
   assign rsp_month_bcd   = date.month_bcd;
   assign rsp_year_bcd    = date.year_bcd;

endmodule

`default_nettype wire

[rtl/utrb_checker.sv]
// utrb_checker: port-level assertions for unix_time_to_rtc_bcd, bound to
// the top level. Depends on utrb_pkg.
`default_nettype none

module utrb_checker import utrb_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  rsp_valid,
   input wire logic [SEC_BCD_W-1:0]  rsp_seconds_bcd,
   input wire logic [MIN_BCD_W-1:0]  rsp_minutes_bcd,
   input wire logic [HOUR_BCD_W-1:0] rsp_hours_bcd,
   input wire logic [DAY_BCD_W-1:0]  rsp_day_bcd,
   input wire logic [WDAY_W-1:0]     rsp_weekday,
   input wire logic [MON_BCD_W-1:0]  rsp_month_bcd,
   input wire logic [YEAR_BCD_W-1:0] rsp_year_bcd
);

   // Every transaction yields its result after the fixed latency
   a_txn_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LATENCY rsp_valid)
      else $error("transaction without result");

   // No result appears without a transaction behind it
   a_result_has_txn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LATENCY))
      else $error("result without transaction");

   a_busy_in_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

   a_time_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_seconds_bcd[6:4] <= 3'd5) && (rsp_seconds_bcd[3:0] <= 4'd9)
         && (rsp_minutes_bcd[6:4] <= 3'd5) && (rsp_minutes_bcd[3:0] <= 4'd9)
         && (rsp_hours_bcd[3:0] <= 4'd9) && (rsp_hours_bcd[5:4] <= 2'd2)
         && !((rsp_hours_bcd[5:4] == 2'd2) && (rsp_hours_bcd[3:0] > 4'd3)))
      else $error("time field out of range");

   a_date_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weekday <= 3'd6) && (rsp_day_bcd != 6'd0)
         && (rsp_day_bcd[3:0] <= 4'd9) && (rsp_day_bcd[5:4] <= 2'd3)
         && (rsp_month_bcd != 5'd0) && (rsp_month_bcd[3:0] <= 4'd9)
         && !(rsp_month_bcd[4] && (rsp_month_bcd[3:0] > 4'd2))
         && (rsp_year_bcd[7:4] <= 4'd9) && (rsp_year_bcd[3:0] <= 4'd9))
      else $error("date field out of range");

endmodule

bind unix_time_to_rtc_bcd utrb_checker u_utrb_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_seconds_bcd (rsp_seconds_bcd),
   .rsp_minutes_bcd (rsp_minutes_bcd),
   .rsp_hours_bcd   (rsp_hours_bcd),
   .rsp_day_bcd     (rsp_day_bcd),
   .rsp_weekday     (rsp_weekday),
   .rsp_month_bcd   (rsp_month_bcd),
   .rsp_year_bcd    (rsp_year_bcd)
);

`default_nettype wire

[dv/unix_time_to_rtc_bcd_test.sv]
// unix_time_to_rtc_bcd_test: self-checking testbench for the seconds-to-RTC
// register converter. Depends on utrb_pkg and unix_time_to_rtc_bcd (rtl/).
// Drives directed and random second counts and checks every register byte.
module unix_time_to_rtc_bcd_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     UTC_W        = utrb_pkg::UTC_W;
   localparam int     RSP_LATENCY  = utrb_pkg::RSP_LATENCY;
   localparam longint DAY_SECS     = 86400;
   localparam longint CIVIL_SHIFT  = 719468;
   localparam longint ERA_DAYS     = 146097;
   localparam longint WINDOW_FIRST = 2000;
   localparam longint WINDOW_LAST  = 2099;
   localparam longint Y2K_SECS     = 946684800;        // 2000-01-01 00:00:00
   localparam longint Y2100_SECS   = 64'sd4102444800;  // 2100-01-01 00:00:00

   // One set of RTC register bytes, tagged with the count that produced it
   typedef struct {
      logic signed [UTC_W-1:0]         utc_seconds;
      logic [utrb_pkg::SEC_BCD_W-1:0]  seconds_bcd;
      logic [utrb_pkg::MIN_BCD_W-1:0]  minutes_bcd;
      logic [utrb_pkg::HOUR_BCD_W-1:0] hours_bcd;
      logic [utrb_pkg::DAY_BCD_W-1:0]  day_bcd;
      logic [utrb_pkg::WDAY_W-1:0]     weekday;
      logic [utrb_pkg::MON_BCD_W-1:0]  month_bcd;
      logic [utrb_pkg::YEAR_BCD_W-1:0] year_bcd;
   } rtc_regs_type;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic signed [UTC_W-1:0]         req_utc_seconds;
   logic                            rsp_valid;
   logic [utrb_pkg::SEC_BCD_W-1:0]  rsp_seconds_bcd;
   logic [utrb_pkg::MIN_BCD_W-1:0]  rsp_minutes_bcd;
   logic [utrb_pkg::HOUR_BCD_W-1:0] rsp_hours_bcd;
   logic [utrb_pkg::DAY_BCD_W-1:0]  rsp_day_bcd;
   logic [utrb_pkg::WDAY_W-1:0]     rsp_weekday;
   logic [utrb_pkg::MON_BCD_W-1:0]  rsp_month_bcd;
   logic [utrb_pkg::YEAR_BCD_W-1:0] rsp_year_bcd;

   rtc_regs_type awaiting_regs[$];   // predicted register sets, oldest first
   int           mismatch_count = 0;

   unix_time_to_rtc_bcd dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_utc_seconds (req_utc_seconds),
      .rsp_valid       (rsp_valid),
      .rsp_seconds_bcd (rsp_seconds_bcd),
      .rsp_minutes_bcd (rsp_minutes_bcd),
      .rsp_hours_bcd   (rsp_hours_bcd),
      .rsp_day_bcd     (rsp_day_bcd),
      .rsp_weekday     (rsp_weekday),
      .rsp_month_bcd   (rsp_month_bcd),
      .rsp_year_bcd    (rsp_year_bcd)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the pipeline hangs or results never show up
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Two BCD digits of a value below 100
   function automatic logic [7:0] two_digit_bcd(input longint v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   // Split the count into day and second of day (floor division), then run
   // the era-based days-to-civil conversion on the day number.
   function automatic rtc_regs_type rtc_regs_from_seconds(
         input logic signed [UTC_W-1:0] secs);
      rtc_regs_type regs;
      longint       t, day_num, sod, z, era, doe, yoe, doy, mp, dom, mon, year, wd, yy;
      t       = longint'(secs);
      day_num = t / DAY_SECS;
      sod     = t % DAY_SECS;
      // round the day toward minus infinity so second of day stays positive
      if (sod < 0) begin
         sod     += DAY_SECS;
         day_num -= 1;
      end
      z    = day_num + CIVIL_SHIFT;
      era  = (z >= 0 ? z : z - (ERA_DAYS - 1)) / ERA_DAYS;
      doe  = z - era * ERA_DAYS;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      dom  = doy - (153 * mp + 2) / 5 + 1;
      mon  = (mp < 10) ? mp + 3 : mp - 9;
      year = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
      // day zero was a Thursday
      wd   = ((day_num + 4) % 7 + 7) % 7;
      yy   = (year >= WINDOW_FIRST && year <= WINDOW_LAST) ? year - WINDOW_FIRST : 0;

      regs.utc_seconds = secs;
      regs.seconds_bcd = 7'(two_digit_bcd(sod % 60));
      regs.minutes_bcd = 7'(two_digit_bcd((sod / 60) % 60));
      regs.hours_bcd   = 6'(two_digit_bcd(sod / 3600));
      regs.day_bcd     = 6'(two_digit_bcd(dom));
      regs.weekday     = 3'(wd);
      regs.month_bcd   = 5'(two_digit_bcd(mon));
      regs.year_bcd    = two_digit_bcd(yy);
      return regs;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic signed [UTC_W-1:0] secs,
                              input logic [7:0] want, input logic [7:0] got);
      if (got !== want)
         report_mismatch($sformatf("%s for %0d: got %h, want %h", name, secs, got, want));
   endtask

   // Record each accepted transaction and compare each result strobe with the
   // oldest prediction. Both sides are sampled on the rising edge, before
   // the block updates its outputs.
   always @(posedge clock) begin
      rtc_regs_type want;
      if (!reset) begin
         if (start === 1'b1 && busy === 1'b0)
            awaiting_regs.push_back(rtc_regs_from_seconds(req_utc_seconds));
         if (rsp_valid !== 1'b0) begin
            if (awaiting_regs.size() == 0) begin
               report_mismatch("result strobe with no transaction outstanding");
            end else begin
               want = awaiting_regs.pop_front();
               check_field("rsp_valid", want.utc_seconds, 8'd1, 8'(rsp_valid));
               check_field("seconds_bcd", want.utc_seconds, 8'(want.seconds_bcd),
                           8'(rsp_seconds_bcd));
               check_field("minutes_bcd", want.utc_seconds, 8'(want.minutes_bcd),
                           8'(rsp_minutes_bcd));
               check_field("hours_bcd", want.utc_seconds, 8'(want.hours_bcd),
                           8'(rsp_hours_bcd));
               check_field("day_bcd", want.utc_seconds, 8'(want.day_bcd), 8'(rsp_day_bcd));
               check_field("weekday", want.utc_seconds, 8'(want.weekday), 8'(rsp_weekday));
               check_field("month_bcd", want.utc_seconds, 8'(want.month_bcd),
                           8'(rsp_month_bcd));
               check_field("year_bcd", want.utc_seconds, want.year_bcd, rsp_year_bcd);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Present one count and hold it until the block takes it. Start stays
   // high on return, so the caller either issues again or drops it.
   task automatic issue_time(input longint secs);
      @(negedge clock);
      start           <= 1'b1;
      req_utc_seconds <= UTC_W'(secs);
      // busy only moves on rising edges, so the falling-edge value holds
      while (busy !== 1'b0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // Now and then, about one time in three, idle the request side
   task automatic maybe_pause();
      int gap;
      if ($urandom_range(99) < 35) begin
         gap = $urandom_range(1, 2);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
   endtask

   task automatic issue_paced(input longint secs);
      maybe_pause();
      issue_time(secs);
   endtask

   // Drop start and hold off until every predicted result has been checked
   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (awaiting_regs.size() != 0)
         @(negedge clock);
   endtask

   // Pick a count that stresses the conversion: inside the two-digit year
   // window, at a day or era edge, or anywhere in the 40-bit range.
   function automatic longint pick_seconds();
      longint                  day_num, ofs;
      logic signed [UTC_W-1:0] raw;
      int                      kind;
      kind = $urandom_range(99);
      if (kind < 35)
         return longint'($urandom_range(32'(Y2100_SECS - 1), 32'(Y2K_SECS)));
      if (kind < 55) begin
         day_num = longint'($urandom_range(4_000_000)) - 2_000_000;
         case ($urandom_range(3))
            0:       ofs = 0;
            1:       ofs = DAY_SECS - 1;
            2:       ofs = -1;
            default: ofs = longint'($urandom_range(32'(DAY_SECS - 1)));
         endcase
         return day_num * DAY_SECS + ofs;
      end
      if (kind < 65) begin
         // first day of a 400-year era, plus or minus a day
         day_num = (longint'($urandom_range(72)) - 36) * ERA_DAYS - CIVIL_SHIFT
                   + longint'($urandom_range(2)) - 1;
         return day_num * DAY_SECS + longint'($urandom_range(32'(DAY_SECS - 1)));
      end
      raw = UTC_W'({$urandom(), $urandom()});
      return longint'(raw);
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Epoch and the seconds around it, where floor division flips sign
   task automatic test_epoch_and_sign();
      issue_paced(0);
      issue_paced(1);
      issue_paced(-1);
      issue_paced(DAY_SECS - 1);
      issue_paced(DAY_SECS);
      issue_paced(-DAY_SECS);
      issue_paced(-DAY_SECS - 1);
   endtask

   // Most positive and most negative counts, over ten millennia out, and minus two
   task automatic test_range_extremes();
      issue_paced(64'sd549755813887);
      issue_paced(-64'sd549755813888);
      issue_paced(-64'sd2);
   endtask

   // Edges of the 2000..2099 window where the year byte drops to zero
   task automatic test_century_window();
      issue_paced(Y2K_SECS - 1);
      issue_paced(Y2K_SECS);
      issue_paced(Y2100_SECS - 1);
      issue_paced(Y2100_SECS);
   endtask

   // Leap days, the skipped leap days of 2100 and 1900 and the start of era zero
   task automatic test_calendar_edges();
      issue_paced(951782400);                        // 2000-02-29
      issue_paced(1709164799);                       // 2024-02-28 23:59:59
      issue_paced(1709164800);                       // 2024-02-29
      issue_paced(64'sd4107456000);                  // 2100-02-28
      issue_paced(64'sd4107542400);                  // 2100-03-01
      issue_paced(-CIVIL_SHIFT * DAY_SECS);          // 0000-03-01
      issue_paced(-CIVIL_SHIFT * DAY_SECS - 1);      // 0000-02-29 23:59:59
      issue_paced(-64'sd2208988800);                 // 1900-01-01
      issue_paced(-64'sd2203977600);                 // 1900-02-28
   endtask

   // Stop issuing until the pipeline is empty, then resume
   task automatic test_drain_pause();
      int n;
      for (n = 0; n < 20; n++)
         issue_time(pick_seconds());
      wait_for_drain();
      for (n = 0; n < 20; n++)
         issue_paced(pick_seconds());
   endtask

   // Random counts with random gaps on the request side
   task automatic test_random_paced(input int count);
      int n;
      for (n = 0; n < count; n++)
         issue_paced(pick_seconds());
   endtask

   // Random counts issued on every clock, no gaps at all
   task automatic test_back_to_back(input int count);
      int n;
      for (n = 0; n < count; n++)
         issue_time(pick_seconds());
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_utc_seconds = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_epoch_and_sign();
      test_range_extremes();
      test_century_window();
      test_calendar_edges();
      test_drain_pause();
      test_random_paced(700);
      test_back_to_back(300);
      test_random_paced(40);

      // drain, then give a stray late strobe time to show up
      wait_for_drain();
      repeat (RSP_LATENCY + 8) @(negedge clock);

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/utrb_pkg.sv
rtl/utrb_div_stage.sv
rtl/utrb_day_split.sv
rtl/utrb_clock_fields.sv
rtl/utrb_civil_date.sv
rtl/unix_time_to_rtc_bcd.sv
rtl/utrb_checker.sv
dv/unix_time_to_rtc_bcd_test.sv
